### sv/nst_pkg.sv
// ----------------------------------------------------------------------------
// nst_pkg: shared definitions for the node slot table
// Command and status codes, controller states and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package nst_pkg;

  // Default table size and stored address width in bytes
  localparam int NODES_DEF      = 64;
  localparam int ADDR_BYTES_DEF = 8;

  // Generation value that means "unknown"
  localparam logic [63:0] GEN_UNKNOWN = 64'hffff_ffff_ffff_ffff;

  // Command codes
  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_SET    = 3'd1;
  localparam logic [2:0] CMD_MARK   = 3'd2;
  localparam logic [2:0] CMD_QUERY  = 3'd3;
  localparam logic [2:0] CMD_LOOKUP = 3'd4;

  // Slot status codes
  localparam logic [1:0] ST_NONEXISTENT = 2'd0;
  localparam logic [1:0] ST_DEAD        = 2'd1;
  localparam logic [1:0] ST_ALIVE       = 2'd2;
  localparam logic [1:0] ST_OTHER       = 2'd3;

  // Controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PREF,
    S_SCAN,
    S_WRITE,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

### sv/node_slot_table.sv
// ----------------------------------------------------------------------------
// node_slot_table: table of node slots with add, set, mark, query, lookup
// All slot state lives in one RAM word per slot, walked by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall) carries one command transaction;
//   response channel (rsp_valid / rsp_stall) returns exactly one result
//   transaction per request, in order.
//   The block handles one request at a time; req_stall is high while a
//   request is in progress or the result cannot yet be placed.
//   Steps from accept to result valid:
//     set, mark          read slot, write slot, load result
//     query, no-ops      load result
//     add with preferred slot kept   read slot, check slot, write slot, load result
//     add by scan        scan, write slot, load result; read and check of
//                        the preferred slot first when it is refused
//     lookup             scan, load result
//   The scan reads one slot per cycle and checks it as its data returns.
//   After reset a clearing pass writes every slot to zero, during which no
//   request is accepted.
//   A stalled result waits in the output register; the next request is
//   accepted meanwhile and finishes once that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module node_slot_table #(
  parameter int NODES      = nst_pkg::NODES_DEF,
  parameter int ADDR_BYTES = nst_pkg::ADDR_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [2:0]  command,
  input  wire logic [5:0]  node_id,
  input  wire logic [63:0] address,
  input  wire logic [3:0]  compare_bytes,
  input  wire logic [63:0] generation,
  input  wire logic [1:0]  new_status,
  // response channel
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic [5:0]       slot_id,
  output logic             ok,
  output logic [1:0]       slot_status,
  output logic [63:0]      slot_generation,
  output logic [63:0]      slot_address
);

  localparam int NODE_W = $clog2(NODES);
  localparam int ADDR_W = 8 * ADDR_BYTES;
  localparam int ENT_W  = 2 + 64 + ADDR_W;

  localparam logic [NODE_W-1:0] LAST_SLOT = NODE_W'(NODES - 1);
  localparam logic [NODE_W-1:0] FIRST_SLOT = NODE_W'(1);

  nst_pkg::state_t state, state_next;

  // latched request
  logic [2:0]        lat_cmd;
  logic [ADDR_W-1:0] lat_addr;
  logic [3:0]        lat_cmp;
  logic [63:0]       lat_gen;
  logic [1:0]        lat_nst;

  // sequencer registers
  logic [NODE_W-1:0] clr_ptr;
  logic [NODE_W-1:0] scan_ptr;
  logic [NODE_W-1:0] chk_ptr;
  logic              chk_vld;
  logic [NODE_W-1:0] tgt;
  logic [NODE_W-1:0] highest;

  // pending result
  logic [5:0] res_slot;
  logic       res_ok;
  logic       res_q;

  // RAM ports
  logic              ram_wr_en;
  logic [NODE_W-1:0] ram_wr_addr;
  logic [ENT_W-1:0]  ram_wr_data;
  logic              ram_rd_en;
  logic [NODE_W-1:0] ram_rd_addr;
  logic [ENT_W-1:0]  ram_rd_data;

  nst_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NODES)
  ) u_slots (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // slot word fields: {status, generation, address}
  logic [1:0]        rd_st;
  logic [63:0]       rd_gen;
  logic [ADDR_W-1:0] rd_a;

  assign rd_st  = ram_rd_data[ENT_W-1 -: 2];
  assign rd_gen = ram_rd_data[ADDR_W +: 64];
  assign rd_a   = ram_rd_data[ADDR_W-1:0];

  // request decode
  logic              accept;
  logic              id_ok;
  logic [NODE_W-1:0] idn;
  logic              query_hit;

  assign req_stall = (state != nst_pkg::S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign id_ok     = (32'(node_id) < 32'(NODES));
  assign idn       = NODE_W'(node_id);
  assign query_hit = (command == nst_pkg::CMD_QUERY) && id_ok && (idn <= highest);

  // lookup byte mask, saturates at the stored width
  logic [ADDR_W-1:0] lk_mask;

  always_comb begin
    for (int b = 0; b < ADDR_BYTES; b++) begin
      lk_mask[8*b +: 8] = {8{(4'(b) < lat_cmp)}};
    end
  end

  // shared compare unit for the scan
  logic              is_add;
  logic              is_mark;
  logic              scan_hit;
  logic [NODE_W-1:0] scan_last;

  assign is_add    = (lat_cmd == nst_pkg::CMD_ADD);
  assign is_mark   = (lat_cmd == nst_pkg::CMD_MARK);
  assign scan_last = is_add ? LAST_SLOT : highest;
  assign scan_hit  = is_add ? (rd_st != nst_pkg::ST_ALIVE)
                            : ((rd_st == nst_pkg::ST_ALIVE || rd_st == nst_pkg::ST_OTHER) &&
                               (((rd_a ^ lat_addr) & lk_mask) == '0));

  // new slot word for fill or mark
  logic [63:0]      fill_gen;
  logic [ENT_W-1:0] upd_word;

  assign fill_gen = (lat_gen != nst_pkg::GEN_UNKNOWN) ? lat_gen :
                    (rd_gen == nst_pkg::GEN_UNKNOWN)  ? 64'd1 : rd_gen + 64'd1;
  assign upd_word = is_mark ? {lat_nst, rd_gen, rd_a}
                            : {nst_pkg::ST_ALIVE, fill_gen, lat_addr};

  logic res_load;
  assign res_load = (state == nst_pkg::S_DONE) && (!rsp_valid || !rsp_stall);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nst_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and RAM control
  always_comb begin
    state_next  = state;
    ram_rd_en   = 1'b0;
    ram_rd_addr = scan_ptr;
    ram_wr_en   = 1'b0;
    ram_wr_addr = tgt;
    ram_wr_data = upd_word;
    unique case (state)
      nst_pkg::S_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_ptr;
        ram_wr_data = '0;
        if (clr_ptr == LAST_SLOT) begin
          state_next = nst_pkg::S_IDLE;
        end
      end
      nst_pkg::S_IDLE: begin
        if (req_valid) begin
          unique case (command) inside
            nst_pkg::CMD_ADD: begin
              if (id_ok && node_id != 6'd0) begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = idn;
                state_next  = nst_pkg::S_PREF;
              end else begin
                state_next = nst_pkg::S_SCAN;
              end
            end
            nst_pkg::CMD_SET, nst_pkg::CMD_MARK: begin
              if (id_ok) begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = idn;
                state_next  = nst_pkg::S_WRITE;
              end else begin
                state_next = nst_pkg::S_DONE;
              end
            end
            nst_pkg::CMD_QUERY: begin
              ram_rd_en   = query_hit;
              ram_rd_addr = idn;
              state_next  = nst_pkg::S_DONE;
            end
            nst_pkg::CMD_LOOKUP: begin
              state_next = (highest != '0) ? nst_pkg::S_SCAN : nst_pkg::S_DONE;
            end
            default: begin
              state_next = nst_pkg::S_DONE;
            end
          endcase
        end
      end
      nst_pkg::S_PREF: begin
        // preferred slot kept unless alive with another address
        if (rd_st == nst_pkg::ST_ALIVE && rd_a != lat_addr) begin
          state_next = nst_pkg::S_SCAN;
        end else begin
          state_next = nst_pkg::S_WRITE;
        end
      end
      nst_pkg::S_SCAN: begin
        if (chk_vld && scan_hit) begin
          state_next = is_add ? nst_pkg::S_WRITE : nst_pkg::S_DONE;
        end else if (chk_vld && chk_ptr == scan_last) begin
          state_next = nst_pkg::S_DONE;
        end else begin
          ram_rd_en = 1'b1;
        end
      end
      nst_pkg::S_WRITE: begin
        ram_wr_en  = 1'b1;
        state_next = nst_pkg::S_DONE;
      end
      nst_pkg::S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = nst_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = nst_pkg::S_IDLE;
      end
    endcase
  end

  // control registers with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr   <= '0;
      highest   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == nst_pkg::S_CLEAR) begin
        clr_ptr <= clr_ptr + FIRST_SLOT;
      end
      // highest id follows fills and marks to a present status
      if (state == nst_pkg::S_WRITE && (!is_mark || lat_nst != nst_pkg::ST_NONEXISTENT) &&
          tgt > highest) begin
        highest <= tgt;
      end
      if (res_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // request latch, scan pointers and pending result
  always_ff @(posedge clk) begin
    if (accept) begin
      lat_cmd  <= command;
      lat_addr <= address[ADDR_W-1:0];
      lat_cmp  <= compare_bytes;
      lat_gen  <= generation;
      lat_nst  <= new_status;
      tgt      <= idn;
      scan_ptr <= FIRST_SLOT;
      chk_vld  <= 1'b0;
      res_slot <= 6'd0;
      res_ok   <= query_hit;
      res_q    <= query_hit;
    end
    if (state == nst_pkg::S_SCAN) begin
      if (chk_vld && scan_hit) begin
        tgt <= chk_ptr;
        if (!is_add) begin
          res_slot <= 6'(chk_ptr);
          res_ok   <= 1'b1;
        end
      end else begin
        chk_ptr  <= scan_ptr;
        scan_ptr <= scan_ptr + FIRST_SLOT;
        chk_vld  <= 1'b1;
      end
    end
    if (state == nst_pkg::S_WRITE && is_add) begin
      res_slot <= 6'(tgt);
      res_ok   <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (res_load) begin
      slot_id         <= res_slot;
      ok              <= res_ok;
      slot_status     <= res_q ? rd_st : nst_pkg::ST_NONEXISTENT;
      slot_generation <= res_q ? rd_gen : 64'd0;
      slot_address    <= res_q ? 64'(rd_a) : 64'd0;
    end
  end

endmodule

`default_nettype wire

### sv/nst_ram.sv
// ----------------------------------------------------------------------------
// nst_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds
// while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module nst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### bench/tb_node_slot_table.sv
// ----------------------------------------------------------------------------
// tb_node_slot_table: self-checking bench for the node slot table
// Drives add, set, mark, query, lookup and the spare opcodes with random
// idle cycles on both channels. Every accepted request is run through an
// in-bench copy of the table, and each response is checked field by field.
// ----------------------------------------------------------------------------
module tb_node_slot_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOTS    = nst_pkg::NODES_DEF;
  localparam int ABYTES    = nst_pkg::ADDR_BYTES_DEF;
  localparam int CYC_LIMIT = 500000;
  localparam int ERR_SHOWN = 40;

  // Opcodes the block treats as no-ops
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [5:0]  id;
    logic [63:0] addr;
    logic [3:0]  cmp;
    logic [63:0] gen;
    logic [1:0]  nst;
  } slot_req_t;

  typedef struct packed {
    logic [5:0]  slot;
    logic        ok;
    logic [1:0]  st;
    logic [63:0] gen;
    logic [63:0] addr;
  } slot_rsp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [2:0]  command = nst_pkg::CMD_QUERY;
  logic [5:0]  node_id = '0;
  logic [63:0] address = '0;
  logic [3:0]  compare_bytes = '0;
  logic [63:0] generation = '0;
  logic [1:0]  new_status = nst_pkg::ST_NONEXISTENT;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [5:0]  slot_id;
  logic        ok;
  logic [1:0]  slot_status;
  logic [63:0] slot_generation;
  logic [63:0] slot_address;

  node_slot_table dut (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .command        (command),
    .node_id        (node_id),
    .address        (address),
    .compare_bytes  (compare_bytes),
    .generation     (generation),
    .new_status     (new_status),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .slot_id        (slot_id),
    .ok             (ok),
    .slot_status    (slot_status),
    .slot_generation(slot_generation),
    .slot_address   (slot_address)
  );

  // Clock: 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow table
  logic [1:0]  tbl_status [NSLOTS];
  logic [63:0] tbl_gen    [NSLOTS];
  logic [63:0] tbl_addr   [NSLOTS];
  logic [5:0]  tbl_top;

  slot_req_t   pending_reqs [$];
  slot_rsp_t   replies_due  [$];
  logic [63:0] addr_pool    [6];

  int issued       = 0;
  int replies_seen = 0;
  int mismatches   = 0;
  int full_adds    = 0;
  int lookup_hits  = 0;
  int kept_prefs   = 0;
  int cycle_count  = 0;
  logic req_taken  = 1'b0;

  function automatic logic [63:0] byte_span(int unsigned nb);
    if (nb >= 8) return 64'hffff_ffff_ffff_ffff;
    return (64'd1 << (8 * nb)) - 64'd1;
  endfunction

  // Write a slot as alive, advancing an unknown generation
  function automatic void store_node(logic [5:0] id, logic [63:0] addr, logic [63:0] gen);
    tbl_addr[id] = addr & byte_span(ABYTES);
    if (gen == nst_pkg::GEN_UNKNOWN)
      tbl_gen[id] = (tbl_gen[id] == nst_pkg::GEN_UNKNOWN) ? 64'd1 : tbl_gen[id] + 64'd1;
    else
      tbl_gen[id] = gen;
    tbl_status[id] = nst_pkg::ST_ALIVE;
    if (id > tbl_top) tbl_top = id;
  endfunction

  // Apply one request to the shadow table and return the expected response
  function automatic slot_rsp_t predict_reply(slot_req_t r);
    slot_rsp_t   y;
    logic [5:0]  pick;
    logic [63:0] addr;
    logic [63:0] mask;
    int unsigned nb;
    int          i;
    y    = '0;
    addr = r.addr & byte_span(ABYTES);
    case (r.cmd)
      nst_pkg::CMD_ADD: begin
        pick = r.id;
        if (pick != 0 && tbl_status[pick] == nst_pkg::ST_ALIVE && tbl_addr[pick] != addr)
          pick = '0;
        if (pick != 0) kept_prefs++;
        if (pick == 0) begin
          for (i = 1; i < NSLOTS; i++) begin
            if (tbl_status[i] != nst_pkg::ST_ALIVE) begin
              pick = 6'(i);
              break;
            end
          end
        end
        if (pick != 0) begin
          store_node(pick, addr, r.gen);
          y.slot = pick;
          y.ok   = 1'b1;
        end else begin
          full_adds++;
        end
      end
      nst_pkg::CMD_SET: store_node(r.id, addr, r.gen);
      nst_pkg::CMD_MARK: begin
        tbl_status[r.id] = r.nst;
        if (r.nst != nst_pkg::ST_NONEXISTENT && r.id > tbl_top) tbl_top = r.id;
      end
      nst_pkg::CMD_QUERY: begin
        if (r.id <= tbl_top) begin
          y.ok   = 1'b1;
          y.st   = tbl_status[r.id];
          y.gen  = tbl_gen[r.id];
          y.addr = tbl_addr[r.id];
        end
      end
      nst_pkg::CMD_LOOKUP: begin
        nb   = (r.cmp > ABYTES) ? ABYTES : r.cmp;
        mask = byte_span(nb);
        for (i = 1; i <= tbl_top && i < NSLOTS; i++) begin
          if (tbl_status[i] != nst_pkg::ST_NONEXISTENT && tbl_status[i] != nst_pkg::ST_DEAD &&
              ((tbl_addr[i] ^ addr) & mask) == 0) begin
            y.slot = 6'(i);
            y.ok   = 1'b1;
            lookup_hits++;
            break;
          end
        end
      end
      default: ;
    endcase
    return y;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= ERR_SHOWN)
      $display("MISMATCH %s: got %h want %h (response %0d)", what, got, want, replies_seen);
  endtask

  task automatic compare_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report(what, got, want);
  endtask

  // Stimulus helpers
  function automatic slot_req_t mk_req(logic [2:0] cmd, logic [5:0] id, logic [63:0] addr,
                                       logic [3:0] cmp, logic [63:0] gen, logic [1:0] nst);
    slot_req_t r;
    r.cmd  = cmd;
    r.id   = id;
    r.addr = addr;
    r.cmp  = cmp;
    r.gen  = gen;
    r.nst  = nst;
    return r;
  endfunction

  function automatic logic [63:0] pick_addr(logic [5:0] id);
    int roll;
    roll = $urandom_range(0, 99);
    if (id != 0 && roll < 35) return addr_pool[id % 6];
    if (roll < 60) return addr_pool[$urandom_range(0, 5)];
    // shares the low bytes of a pool entry only
    if (roll < 80)
      return addr_pool[$urandom_range(0, 5)] ^
             ({$urandom, $urandom} << (8 * $urandom_range(1, 7)));
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_gen();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return nst_pkg::GEN_UNKNOWN;
    if (roll < 55) return nst_pkg::GEN_UNKNOWN - 64'($urandom_range(1, 3));
    if (roll < 65) return 64'd0;
    return {$urandom, $urandom};
  endfunction

  function automatic slot_req_t random_req(bit fill_burst);
    slot_req_t r;
    int        roll;
    r      = '0;
    roll   = fill_burst ? 0 : $urandom_range(0, 99);
    r.id   = 6'($urandom_range(0, 63));
    r.cmp  = 4'($urandom_range(0, 15));
    r.nst  = 2'($urandom_range(0, 3));
    r.gen  = pick_gen();
    if (roll < 25) begin
      r.cmd = nst_pkg::CMD_ADD;
      if ($urandom_range(0, 99) < 40 || fill_burst) r.id = '0;
    end else if (roll < 35) begin
      r.cmd = nst_pkg::CMD_SET;
    end else if (roll < 55) begin
      r.cmd = nst_pkg::CMD_MARK;
    end else if (roll < 72) begin
      r.cmd = nst_pkg::CMD_QUERY;
    end else if (roll < 95) begin
      r.cmd = nst_pkg::CMD_LOOKUP;
    end else begin
      r.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    end
    r.addr = pick_addr(r.id);
    return r;
  endfunction

  // Idle rolls are suppressed during a quiet stretch in the middle of the run
  function automatic bit take_idle();
    if (issued >= 500 && issued < 760) return 1'b0;
    return $urandom_range(0, 99) < 23;
  endfunction

  // Request driver: presents the next pending transaction at the falling edge
  always @(negedge clk) begin
    slot_req_t r;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (pending_reqs.size() > 0 && !take_idle()) begin
        r = pending_reqs.pop_front();
        command       <= r.cmd;
        node_id       <= r.id;
        address       <= r.addr;
        compare_bytes <= r.cmp;
        generation    <= r.gen;
        new_status    <= r.nst;
        req_valid     <= 1'b1;
        issued++;
      end else begin
        req_valid <= 1'b0;
      end
    end
    rsp_stall <= !rst && take_idle();
  end

  // Monitor: checks responses, predicts accepted requests
  always @(posedge clk) begin
    slot_rsp_t want;
    req_taken <= !rst && req_valid && !req_stall;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (replies_due.size() == 0) begin
          report("response with none outstanding", {58'd0, slot_id}, 64'd0);
        end else begin
          want = replies_due.pop_front();
          compare_field("slot_id", {58'd0, slot_id}, {58'd0, want.slot});
          compare_field("ok", {63'd0, ok}, {63'd0, want.ok});
          compare_field("slot_status", {62'd0, slot_status}, {62'd0, want.st});
          compare_field("slot_generation", slot_generation, want.gen);
          compare_field("slot_address", slot_address, want.addr);
        end
        replies_seen++;
      end
      if (req_valid && !req_stall)
        replies_due.push_back(predict_reply(mk_req(command, node_id, address,
                                                   compare_bytes, generation, new_status)));
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYC_LIMIT) begin
      $display("Timeout after %0d cycles, %0d responses outstanding",
               cycle_count, replies_due.size());
      $display("[node_slot_table] ERROR");
      $finish;
    end
  end

  initial begin
    logic [63:0] a_addr;
    logic [63:0] b_addr;
    logic [63:0] c_addr;
    int          i;
    int          rnd;

    a_addr = 64'h0123_4567_89ab_cdef;
    b_addr = 64'hfedc_ba98_7654_3210;
    c_addr = 64'h5555_aaaa_5555_aaaa;
    for (i = 0; i < NSLOTS; i++) begin
      tbl_status[i] = nst_pkg::ST_NONEXISTENT;
      tbl_gen[i]    = '0;
      tbl_addr[i]   = '0;
    end
    tbl_top = '0;
    for (i = 0; i < 6; i++) addr_pool[i] = {$urandom, $urandom};

    // Directed: empty table, preferred-slot rules, generation wrap, lookup lengths
    pending_reqs.push_back(mk_req(nst_pkg::CMD_QUERY, 6'd0, '0, 4'd0, '0,
                                  nst_pkg::ST_NONEXISTENT));
    pending_reqs.push_back(mk_req(nst_pkg::CMD_QUERY, 6'd63, '0, 4'd0, '0,
                                  nst_pkg::ST_NONEXISTENT));
    pending_reqs.push_back(mk_req(nst_pkg::CMD_LOOKUP, 6'd0, '0, 4'd0, '0,
                                  nst_pkg::ST_NONEXISTENT));
    pending_reqs.push_back(mk_req(nst_pkg::CMD_ADD, 6'd0, a_addr, 4'd8, nst_pkg::GEN_UNKNOWN,
                                  nst_pkg::ST_DEAD));
    pending_reqs.push_back(mk_req(nst_pkg::CMD_ADD, 6'd5, b_addr, 4'd8,
                                  nst_pkg::GEN_UNKNOWN - 64'd1, nst_pkg::ST_DEAD));
    // same address on a live preferred slot: kept, generation reaches all ones
    pending_reqs.push_back(mk_req(nst_pkg::CMD_ADD, 6'd5, b_addr, 4'd8, nst_pkg::GEN_UNKNOWN,
                                  nst_pkg::ST_DEAD));
    // unknown on an all-ones generation restarts at one
    pending_reqs.push_back(mk_req(nst_pkg::CMD_ADD, 6'd5, b_addr, 4'd8, nst_pkg::GEN_UNKNOWN,
                                  nst_pkg::ST_DEAD));
    pending_reqs.push_back(mk_req(nst_pkg::CMD_QUERY, 6'd5, '0, 4'd0, '0,
                                  nst_pkg::ST_NONEXISTENT));
    // different address on a live preferred slot: falls back to a scan
    pending_reqs.push_back(mk_req(nst_pkg::CMD_ADD, 6'd5, c_addr, 4'd8, 64'd7,
                                  nst_pkg::ST_DEAD));
    pending_reqs.push_back(mk_req(nst_pkg::CMD_SET, 6'd63, '1, 4'd15, 64'd0,
                                  nst_pkg::ST_DEAD));
    pending_reqs.push_back(mk_req(nst_pkg::CMD_QUERY, 6'd63, '0, 4'd0, '0,
                                  nst_pkg::ST_NONEXISTENT));
    pending_reqs.push_back(mk_req(nst_pkg::CMD_MARK, 6'd1, '0, 4'd0, '0, nst_pkg::ST_DEAD));
    pending_reqs.push_back(mk_req(nst_pkg::CMD_LOOKUP, 6'd0, a_addr, 4'd8, '0,
                                  nst_pkg::ST_NONEXISTENT));
    pending_reqs.push_back(mk_req(nst_pkg::CMD_MARK, 6'd2, '0, 4'd0, '0, nst_pkg::ST_OTHER));
    // compare length above the address width saturates
    pending_reqs.push_back(mk_req(nst_pkg::CMD_LOOKUP, 6'd0, c_addr, 4'd15, '0,
                                  nst_pkg::ST_NONEXISTENT));
    // zero compare length hits the first slot that is alive or other
    pending_reqs.push_back(mk_req(nst_pkg::CMD_LOOKUP, 6'd0, '1, 4'd0, '0,
                                  nst_pkg::ST_NONEXISTENT));
    pending_reqs.push_back(mk_req(nst_pkg::CMD_LOOKUP, 6'd0,
                                  {40'h12_3456_7890, b_addr[23:0]},
                                  4'd3, '0, nst_pkg::ST_NONEXISTENT));
    // clearing a slot leaves the highest id alone
    pending_reqs.push_back(mk_req(nst_pkg::CMD_MARK, 6'd63, '0, 4'd0, '0,
                                  nst_pkg::ST_NONEXISTENT));
    pending_reqs.push_back(mk_req(nst_pkg::CMD_QUERY, 6'd63, '0, 4'd0, '0,
                                  nst_pkg::ST_NONEXISTENT));
    pending_reqs.push_back(mk_req(nst_pkg::CMD_MARK, 6'd0, '0, 4'd0, '0, nst_pkg::ST_ALIVE));
    pending_reqs.push_back(mk_req(nst_pkg::CMD_SET, 6'd0, c_addr, 4'd0, nst_pkg::GEN_UNKNOWN,
                                  nst_pkg::ST_DEAD));
    pending_reqs.push_back(mk_req(nst_pkg::CMD_QUERY, 6'd0, '0, 4'd0, '0,
                                  nst_pkg::ST_NONEXISTENT));
    for (i = CMD_SPARE_LO; i <= CMD_SPARE_HI; i++)
      pending_reqs.push_back(mk_req(3'(i), 6'd63, '1, 4'hf, '1, nst_pkg::ST_OTHER));

    // Random rounds; two of them open with an add burst that fills the table
    for (rnd = 0; rnd < 6; rnd++) begin
      if (rnd == 1 || rnd == 4)
        for (i = 0; i < 70; i++) pending_reqs.push_back(random_req(1'b1));
      for (i = 0; i < 198; i++) pending_reqs.push_back(random_req(1'b0));
    end

    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Drain: all requests accepted, all responses in, then a quiet tail
    while (pending_reqs.size() != 0 || req_valid) @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Covered %0d transactions: %0d adds on a full table, %0d preferred slots kept,",
             issued, full_adds, kept_prefs);
    $display("%0d lookup hits; %0d responses checked, %0d mismatches",
             lookup_hits, replies_seen, mismatches);
    if (mismatches == 0) begin
      $display("[node_slot_table] OK");
    end else begin
      $display("[node_slot_table] ERROR");
    end
    $finish;
  end

endmodule
